FILE: design/vpc_pkg.sv
package vpc_pkg;

  localparam int VOTER_W    = 6;
  localparam int NUM_VOTERS = 6;
  localparam int FOUR_VOTERS = 4;
  localparam int CNT_W      = 16;
  localparam int CFG_AW     = 4;
  localparam int CFG_DW     = 32;

  typedef logic [VOTER_W-1:0] voter_vec_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  // register index, paddr[3:2]
  typedef enum logic [1:0] {
    REG_PRESS_TICKS = 2'd0,
    REG_MODE_HOLD   = 2'd1,
    REG_OFF_HOLD    = 2'd2,
    REG_NONE        = 2'd3
  } reg_idx_t;

  // hold stage and the action its release selects share one code
  typedef enum logic [1:0] {
    ACT_NONE         = 2'd0,
    ACT_VOTERS_RESET = 2'd1,
    ACT_MODE_CHANGE  = 2'd2,
    ACT_POWER_OFF    = 2'd3
  } action_t;

  localparam cnt_t PRESS_TICKS_RST = cnt_t'(5);
  localparam cnt_t MODE_HOLD_RST   = cnt_t'(100);
  localparam cnt_t OFF_HOLD_RST    = cnt_t'(300);

  function automatic voter_vec_t low_mask(input int n);
    voter_vec_t m;
    m = '0;
    for (int i = 0; i < VOTER_W; i++) begin
      if (i < n) m[i] = 1'b1;
    end
    return m;
  endfunction

  localparam voter_vec_t ALL_MASK  = low_mask(NUM_VOTERS);
  localparam voter_vec_t FOUR_MASK = low_mask(FOUR_VOTERS);

  function automatic voter_vec_t active_mask(input logic six);
    return six ? ALL_MASK : FOUR_MASK;
  endfunction

endpackage

FILE: design/voting_panel_controller_core.sv
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid / in_stall  | voter_buttons_n[5:0], reset_pressed
// out_    | output    | out_valid / out_stall| voted_mask[5:0], all_voted, six_voter_mode,
//         |           |                      | hold_stage[1:0], release_action[1:0]
// cfg     | input     | APB psel/penable     | press_ticks, mode_hold_ticks, off_hold_ticks
//
// One word per cycle unless out_stall holds; path: input register, result register.
// The state update and all compares happen in the single stage between those registers.
// in_stall rises only while the input register is full and the held result is stalled.
// rst_n is synchronous; state registers reset, data registers do not; no clearing pass.
module voting_panel_controller_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [vpc_pkg::VOTER_W-1:0]  in_voter_buttons_n,
  input  logic                         in_reset_pressed,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [vpc_pkg::VOTER_W-1:0]  out_voted_mask,
  output logic                         out_all_voted,
  output logic                         out_six_voter_mode,
  output logic [1:0]                   out_hold_stage,
  output logic [1:0]                   out_release_action,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vpc_pkg::CFG_AW-1:0]   paddr,
  input  logic [vpc_pkg::CFG_DW-1:0]   pwdata,
  output logic [vpc_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready
);
  import vpc_pkg::*;

  // config
  cnt_t     press_ticks_r, mode_hold_r, off_hold_r;
  reg_idx_t cfg_idx;
  logic     cfg_wr;

  // pipeline
  logic       in_valid_r;
  voter_vec_t buttons_r;
  logic       reset_pressed_r;
  logic       out_valid_r;
  voter_vec_t out_voted_r;
  logic       out_all_r;
  logic       out_six_r;
  action_t    out_stage_r;
  action_t    out_action_r;
  logic       advance;

  // block state
  voter_vec_t last_r, last_nxt;
  voter_vec_t voted_r, voted_nxt;
  logic       six_r, six_nxt;
  logic       held_r, held_nxt;
  cnt_t       hold_cnt_r, hold_cnt_nxt;
  action_t    stage_r, stage_nxt;
  action_t    action_nxt;
  logic       all_nxt;

  voter_vec_t pressed_now;
  voter_vec_t act;
  voter_vec_t act_new;
  cnt_t       cnt_inc;
  action_t    stg;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_PRESS_TICKS: prdata = CFG_DW'(press_ticks_r);
      REG_MODE_HOLD:   prdata = CFG_DW'(mode_hold_r);
      REG_OFF_HOLD:    prdata = CFG_DW'(off_hold_r);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_ticks_r <= PRESS_TICKS_RST;
      mode_hold_r   <= MODE_HOLD_RST;
      off_hold_r    <= OFF_HOLD_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PRESS_TICKS: press_ticks_r <= pwdata[CNT_W-1:0];
        REG_MODE_HOLD:   mode_hold_r   <= pwdata[CNT_W-1:0];
        REG_OFF_HOLD:    off_hold_r    <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = in_valid_r && !(out_valid_r && out_stall);
  assign in_stall = in_valid_r && out_valid_r && out_stall;

  always_comb begin
    pressed_now = ~buttons_r & ALL_MASK;
    act         = active_mask(six_r);
    voted_nxt   = voted_r | (pressed_now & last_r & act);
    last_nxt    = (last_r & ~act) | (pressed_now & act);
    six_nxt     = six_r;
    held_nxt    = held_r;
    hold_cnt_nxt = hold_cnt_r;
    stage_nxt   = stage_r;
    action_nxt  = ACT_NONE;
    cnt_inc     = (hold_cnt_r == '1) ? hold_cnt_r : hold_cnt_r + cnt_t'(1);
    stg         = stage_r;

    if (reset_pressed_r && !held_r) begin
      held_nxt     = 1'b1;
      hold_cnt_nxt = '0;
      stage_nxt    = ACT_NONE;
    end else if (held_r) begin
      hold_cnt_nxt = cnt_inc;
      if (stg == ACT_NONE && cnt_inc >= press_ticks_r)         stg = ACT_VOTERS_RESET;
      if (stg == ACT_VOTERS_RESET && cnt_inc >= mode_hold_r)   stg = ACT_MODE_CHANGE;
      if (stg == ACT_MODE_CHANGE && cnt_inc >= off_hold_r)     stg = ACT_POWER_OFF;
      stage_nxt = stg;
      if (!reset_pressed_r) begin
        action_nxt = stg;
        held_nxt   = 1'b0;
        unique case (stg)
          ACT_NONE:         ;
          ACT_VOTERS_RESET: voted_nxt = voted_nxt & ~act;
          ACT_MODE_CHANGE: begin
            voted_nxt = voted_nxt & ~ALL_MASK;
            six_nxt   = ~six_r;
          end
          ACT_POWER_OFF:    voted_nxt = voted_nxt & ~ALL_MASK;
          default: ;
        endcase
      end
    end

    act_new = active_mask(six_nxt);
    all_nxt = ((voted_nxt & act_new) == act_new);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      last_r      <= '0;
      voted_r     <= '0;
      six_r       <= 1'b1;
      held_r      <= 1'b0;
      hold_cnt_r  <= '0;
      stage_r     <= ACT_NONE;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        last_r      <= last_nxt;
        voted_r     <= voted_nxt;
        six_r       <= six_nxt;
        held_r      <= held_nxt;
        hold_cnt_r  <= hold_cnt_nxt;
        stage_r     <= stage_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      buttons_r       <= in_voter_buttons_n;
      reset_pressed_r <= in_reset_pressed;
    end
    if (advance) begin
      out_voted_r  <= voted_nxt;
      out_all_r    <= all_nxt;
      out_six_r    <= six_nxt;
      out_stage_r  <= stage_nxt;
      out_action_r <= action_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_voted_mask     = out_voted_r;
  assign out_all_voted      = out_all_r;
  assign out_six_voter_mode = out_six_r;
  assign out_hold_stage     = out_stage_r;
  assign out_release_action = out_action_r;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

  a_action_is_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_action_r != ACT_NONE) |-> (out_action_r == out_stage_r))
    else $error("release action differs from hold stage");

  a_all_voted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_all_r ==
      ((out_voted_r & active_mask(out_six_r)) == active_mask(out_six_r))))
    else $error("all_voted inconsistent with voted mask");

  a_hold_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_cnt_r == '1) |=> (hold_cnt_r == '1 || hold_cnt_r == '0))
    else $error("hold counter wrapped");

  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && held_r && !reset_pressed_r) |=> !held_r)
    else $error("release did not end the hold");

endmodule

FILE: dv/voting_panel_controller_core_test.sv
module voting_panel_controller_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import vpc_pkg::*;

  typedef struct packed {
    voter_vec_t voted_mask;
    logic       all_voted;
    logic       six_mode;
    action_t    stage;
    action_t    rel_act;
  } panel_word_t;

  class vote_scoreboard;
    cnt_t        press_lim;
    cnt_t        mode_lim;
    cnt_t        off_lim;
    voter_vec_t  last_pressed;
    voter_vec_t  voted;
    logic        six;
    logic        held;
    cnt_t        hold_cnt;
    action_t     stage;
    panel_word_t pending_q[$];
    int          errors;
    int          n_checked;
    int          four_cnt;
    int          all_cnt;
    int          rel_cnt[4];

    function new();
      press_lim    = PRESS_TICKS_RST;
      mode_lim     = MODE_HOLD_RST;
      off_lim      = OFF_HOLD_RST;
      last_pressed = '0;
      voted        = '0;
      six          = 1'b1;
      held         = 1'b0;
      hold_cnt     = '0;
      stage        = ACT_NONE;
      errors       = 0;
      n_checked    = 0;
      four_cnt     = 0;
      all_cnt      = 0;
      foreach (rel_cnt[i]) rel_cnt[i] = 0;
    endfunction

    function void set_reg(reg_idx_t idx, cnt_t val);
      case (idx)
        REG_PRESS_TICKS: press_lim = val;
        REG_MODE_HOLD:   mode_lim  = val;
        REG_OFF_HOLD:    off_lim   = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    // one scan tick: voter scan first, then the reset button
    function void note_tick(voter_vec_t btn_n, logic rst_btn);
      voter_vec_t  now_p;
      voter_vec_t  act;
      action_t     rel;
      panel_word_t w;
      now_p = ~btn_n;
      act   = six ? ALL_MASK : FOUR_MASK;
      rel   = ACT_NONE;
      voted        = voted | (now_p & last_pressed & act);
      last_pressed = (last_pressed & ~act) | (now_p & act);
      if (rst_btn && !held) begin
        held     = 1'b1;
        hold_cnt = '0;
        stage    = ACT_NONE;
      end else if (held) begin
        if (hold_cnt != 16'hFFFF) hold_cnt = hold_cnt + 16'd1;
        if (stage == ACT_NONE && hold_cnt >= press_lim) stage = ACT_VOTERS_RESET;
        if (stage == ACT_VOTERS_RESET && hold_cnt >= mode_lim) stage = ACT_MODE_CHANGE;
        if (stage == ACT_MODE_CHANGE && hold_cnt >= off_lim) stage = ACT_POWER_OFF;
        if (!rst_btn) begin
          rel = stage;
          case (rel)
            ACT_VOTERS_RESET: voted = voted & ~act;
            ACT_MODE_CHANGE: begin
              voted = voted & ~ALL_MASK;
              six   = ~six;
            end
            ACT_POWER_OFF: voted = voted & ~ALL_MASK;
            default: ;
          endcase
          held = 1'b0;
        end
      end
      act          = six ? ALL_MASK : FOUR_MASK;
      w.voted_mask = voted;
      w.all_voted  = ((voted & act) == act);
      w.six_mode   = six;
      w.stage      = stage;
      w.rel_act    = rel;
      pending_q.push_back(w);
    endfunction

    function void compare_field(longint unsigned stamp, string name, logic [5:0] exp_v,
                                logic [5:0] got_v);
      if (got_v !== exp_v) begin
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", stamp, name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(longint unsigned stamp, voter_vec_t mask, logic all_v,
                               logic six_m, logic [1:0] stg, logic [1:0] rel);
      panel_word_t w;
      if (pending_q.size() == 0) begin
        $display("%0t ns: result word with none expected, actual mask %0h", stamp, mask);
        errors++;
        return;
      end
      w = pending_q.pop_front();
      compare_field(stamp, "voted_mask", w.voted_mask, mask);
      compare_field(stamp, "all_voted", 6'(w.all_voted), 6'(all_v));
      compare_field(stamp, "six_voter_mode", 6'(w.six_mode), 6'(six_m));
      compare_field(stamp, "hold_stage", 6'(w.stage), 6'(stg));
      compare_field(stamp, "release_action", 6'(w.rel_act), 6'(rel));
      n_checked++;
      rel_cnt[w.rel_act]++;
      if (!w.six_mode) four_cnt++;
      if (w.all_voted) all_cnt++;
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  voter_vec_t          in_voter_buttons_n = '1;
  logic                in_reset_pressed = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  voter_vec_t          out_voted_mask;
  logic                out_all_voted;
  logic                out_six_voter_mode;
  logic [1:0]          out_hold_stage;
  logic [1:0]          out_release_action;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CFG_AW-1:0]   paddr = '0;
  logic [CFG_DW-1:0]   pwdata = '0;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  vote_scoreboard sb = new();
  bit   tx_idle_on = 1'b0;
  bit   rx_idle_on = 1'b0;
  bit   hold_off_req = 1'b0;
  cnt_t thr[3];
  int   n_settings = 0;

  voting_panel_controller_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_voter_buttons_n (in_voter_buttons_n),
    .in_reset_pressed   (in_reset_pressed),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_voted_mask     (out_voted_mask),
    .out_all_voted      (out_all_voted),
    .out_six_voter_mode (out_six_voter_mode),
    .out_hold_stage     (out_hold_stage),
    .out_release_action (out_release_action),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #6 clk = ~clk;

  initial begin
    #(64'd36_000_000);
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_tick(in_voter_buttons_n, in_reset_pressed);
      if (out_valid && !out_stall) begin
        sb.check_result($time, out_voted_mask, out_all_voted, out_six_voter_mode,
                        out_hold_stage, out_release_action);
      end
    end
  end

  initial begin : rx_side
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (60) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 6) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_tick(voter_vec_t btn_n, logic rst_btn);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_voter_buttons_n <= btn_n;
    in_reset_pressed   <= rst_btn;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, cnt_t val);
    logic [15:0] junk;
    junk = 16'($urandom);
    paddr   <= CFG_AW'({idx, 2'b00});
    pwdata  <= {junk, val};
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    if (idx != REG_NONE) begin
      thr[idx] = val;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (prdata[15:0] !== val) begin
        $display("%0t ns: register %0d readback, expected %0h, actual %0h",
                 $time, idx, val, prdata[15:0]);
        sb.errors++;
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limits(cnt_t p, cnt_t m, cnt_t o);
    write_reg(REG_PRESS_TICKS, p);
    write_reg(REG_MODE_HOLD, m);
    write_reg(REG_OFF_HOLD, o);
    n_settings++;
  endtask

  // buttons persist over several ticks; reset holds land near the thresholds or are short random holds
  task automatic run_random(int count);
    voter_vec_t btn;
    logic       rb;
    int         hold_left;
    int         target;
    int         len;
    int         k;
    btn       = 6'h3F;
    hold_left = 0;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(0, 11))
        0: btn = 6'h3F;
        1: btn = 6'h00;
        2: btn = ~(6'b1 << $urandom_range(0, 5));
        3: btn = voter_vec_t'($urandom);
        default: ;
      endcase
      if (hold_left > 0) begin
        rb = 1'b1;
        hold_left--;
      end else if ($urandom_range(0, 14) == 0) begin
        case ($urandom_range(0, 3))
          0: target = thr[0];
          1: target = thr[1];
          2: target = thr[2];
          default: target = $urandom_range(0, 8);
        endcase
        len = target + $urandom_range(0, 2) - 1;
        if (len < 1) len = 1;
        if (len > 400) len = 400;
        hold_left = len - 1;
        rb = 1'b1;
      end else begin
        rb = 1'b0;
      end
      send_tick(btn, rb);
    end
  endtask

  initial begin : main_seq
    int p;
    int k;
    thr[0] = PRESS_TICKS_RST;
    thr[1] = MODE_HOLD_RST;
    thr[2] = OFF_HOLD_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_tick(6'h3F, 1'b0);
    send_tick(6'h00, 1'b0);
    send_tick(6'h00, 1'b0);
    send_tick(6'h3E, 1'b1);
    send_tick(6'h3F, 1'b0);
    send_tick(6'h2A, 1'b0);
    send_tick(6'h15, 1'b0);
    drain();

    set_limits(16'd1, 16'd2, 16'd3);
    write_reg(REG_NONE, 16'hFFFF);
    send_tick(6'h3F, 1'b1);
    send_tick(6'h3F, 1'b0);
    send_tick(6'h00, 1'b0);
    send_tick(6'h00, 1'b0);
    send_tick(6'h3F, 1'b1);
    send_tick(6'h3F, 1'b1);
    send_tick(6'h3F, 1'b0);
    send_tick(6'h00, 1'b0);
    send_tick(6'h00, 1'b0);
    send_tick(6'h0F, 1'b1);
    send_tick(6'h0F, 1'b1);
    send_tick(6'h0F, 1'b1);
    send_tick(6'h0F, 1'b0);
    drain();

    set_limits(16'd0, 16'd0, 16'd0);
    send_tick(6'h3F, 1'b1);
    send_tick(6'h3F, 1'b0);
    drain();

    // all three stages reached on the same tick
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    set_limits(16'd20, 16'd20, 16'd20);
    send_tick(6'h3F, 1'b1);
    send_tick(6'h3F, 1'b0);
    send_tick(6'h3F, 1'b1);
    for (k = 0; k < 22; k++) send_tick(voter_vec_t'($urandom), 1'b1);
    send_tick(6'h3F, 1'b0);
    drain();

    for (p = 0; p < 6; p++) begin
      case (p)
        0: set_limits(PRESS_TICKS_RST, MODE_HOLD_RST, OFF_HOLD_RST);
        1: set_limits(cnt_t'($urandom_range(0, 12)), cnt_t'($urandom_range(0, 12)),
                      cnt_t'($urandom_range(0, 12)));
        2: set_limits(cnt_t'($urandom_range(0, 40)), cnt_t'($urandom_range(0, 40)),
                      cnt_t'($urandom_range(0, 40)));
        3: set_limits(16'd2, 16'd6, 16'd12);
        4: set_limits(cnt_t'($urandom_range(0, 300)), cnt_t'($urandom_range(0, 300)),
                      cnt_t'($urandom_range(0, 300)));
        default: set_limits(cnt_t'($urandom_range(0, 20)), cnt_t'($urandom_range(0, 20)),
                            cnt_t'($urandom_range(0, 20)));
      endcase
      tx_idle_on = (p == 0 || p == 1 || p == 4);
      rx_idle_on = (p == 0 || p == 2 || p == 3 || p == 4);
      if (p == 3) hold_off_req = 1'b1;
      run_random(340);
      drain();
    end

    repeat (10) @(posedge clk);
    $display("Checked %0d result words over %0d limit settings and one long output stall",
             sb.n_checked, n_settings);
    $display("Releases none/clear/mode/off %0d/%0d/%0d/%0d, four-voter %0d, all-voted %0d",
             sb.rel_cnt[0], sb.rel_cnt[1], sb.rel_cnt[2], sb.rel_cnt[3],
             sb.four_cnt, sb.all_cnt);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

FILE: files.f
design/vpc_pkg.sv
design/voting_panel_controller_core.sv
dv/voting_panel_controller_core_test.sv
